>>> rtl/sha_pkg.sv
// SHA-256 hasher shared types, constants and round functions.
package sha_pkg;

	localparam int unsigned ROUNDS = 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       wr_byte;
		logic [7:0] wr_data;
		logic       cnt_inc;
		logic       start;
		logic       put_len;
		logic       reinit;
		logic       emit_step;
	} cmd_t;

	typedef struct packed {
		logic       busy;
		logic       done;
		logic [5:0] fill;
	} sts_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
			32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
			32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
			32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
			32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[i];
	endfunction

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction

endpackage

>>> rtl/sha_if.sv
// Valid/ready stream interface.
interface sha_if #(parameter int unsigned W = 9) (input logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
	modport monitor (input valid, input payload, input ready);
endinterface

>>> rtl/sha_datapath.sv
// SHA-256 datapath: block words, length counter, schedule, rounds, digest shift.
module sha_datapath (
	input  logic         clk,
	input  logic         arst_n,
	input  sha_pkg::cmd_t cmd,
	output sha_pkg::sts_t sts,
	output logic [31:0]  digest_word
);
	import sha_pkg::*;

	logic [5:0]  fill_q;
	logic [63:0] cnt_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  rnd_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] wnew, wcur, t1, t2, s0, s1;
	logic [63:0] bits;
	logic [31:0] e, a;

	assign bits = {cnt_q[60:0], 3'b000};
	assign e = v_q[4];
	assign a = v_q[0];
	assign s0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wnew = w_q[0] + s0 + w_q[9] + s1;
	assign wcur = w_q[0];
	assign t1 = v_q[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v_q[5]) ^ (~e & v_q[6]))
		+ round_k(rnd_q) + wcur;
	assign t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

	// block bytes land big-endian in the schedule window
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (busy_q) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (busy_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wnew;
		end else begin
			if (cmd.wr_byte) begin
				w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= cmd.wr_data;
			end
			if (cmd.put_len) begin
				w_q[14] <= bits[63:32];
				w_q[15] <= bits[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
		end else begin
			done_q <= 1'b0;
			if (cmd.wr_byte) fill_q <= fill_q + 6'd1;
			if (cmd.cnt_inc) cnt_q <= cnt_q + 64'd1;
			if (cmd.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'(ROUNDS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
			if (done_q) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end
			if (cmd.emit_step) begin
				for (int i = 0; i < 7; i++) h_q[i] <= h_q[i + 1];
				h_q[7] <= h_q[0];
			end
			if (cmd.reinit) begin
				fill_q <= '0;
				cnt_q  <= '0;
				for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
			end
		end
	end

	assign digest_word = h_q[0];
	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.fill = fill_q;

`ifndef ASSERT_OFF
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !cmd.wr_byte) else $error("byte write during compression");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !cmd.start) else $error("start during compression");
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without rounds");
`endif
endmodule

>>> rtl/sha_ctrl.sv
// SHA-256 controller: input handshake, padding sequence, digest output.
module sha_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          in_action,
	input  logic [7:0]    in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [2:0]    out_index,
	output sha_pkg::cmd_t cmd,
	input  sha_pkg::sts_t sts
);
	import sha_pkg::*;

	state_t state_q, state_d;
	logic   final_q;
	logic   len_q;
	logic [2:0] idx_q;
	logic   acc, oacc;

	assign acc  = in_valid && in_ready;
	assign oacc = out_valid && out_ready;
	assign out_index = idx_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && sts.fill == 6'd63) state_d = ST_COMP;
				else if (acc && in_action) state_d = ST_PAD;
			end
			ST_PAD: begin
				if (sts.fill == LEN_POS) state_d = ST_COMP;
				else if (sts.fill == 6'd63) state_d = ST_COMP;
			end
			ST_COMP: begin
				if (sts.done) begin
					if (len_q) state_d = ST_EMIT;
					else if (final_q) state_d = ST_PAD;
					else state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (oacc && idx_q == 3'd7) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (acc) begin
					cmd.wr_byte = 1'b1;
					cmd.wr_data = in_action ? PAD_BYTE : in_data;
					cmd.cnt_inc = !in_action;
					if (sts.fill == 6'd63) cmd.start = 1'b1;
				end
			end
			ST_PAD: begin
				if (sts.fill == LEN_POS) begin
					cmd.put_len = 1'b1;
					cmd.start = 1'b1;
				end else begin
					cmd.wr_byte = 1'b1;
					cmd.wr_data = 8'h00;
					if (sts.fill == 6'd63) cmd.start = 1'b1;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (oacc) begin
					cmd.emit_step = 1'b1;
					if (idx_q == 3'd7) cmd.reinit = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			final_q <= 1'b0;
			len_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (acc) final_q <= in_action;
			// a block that carries the length is the last one of the message
			if (cmd.put_len) len_q <= 1'b1;
			else if (cmd.reinit) len_q <= 1'b0;
			if (oacc) idx_q <= idx_q + 3'd1;
		end
	end

`ifndef ASSERT_OFF
	a_out_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_EMIT) else $error("output outside emit");
	a_reinit_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reinit |-> idx_q == 3'd7) else $error("reinit early");
	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !sts.busy) else $error("input taken while busy");
`endif
endmodule

>>> rtl/sha256_stream_hasher.sv
// Streaming SHA-256 hasher top level.
// Input channel in_req carries {action, data_byte}; action 0 appends a byte,
// action 1 finishes the message. Output channel out_rsp carries
// {digest_word, word_index, last_word}, eight words per finish, word 0 first.
// The 64th byte of a block starts the round unit, which runs one round
// per cycle; no further request is taken until the rounds are done. A
// finish writes padding one byte per cycle up to byte 56, compresses
// (a second block when fewer than 9 bytes were free), then presents the
// eight words; each word waits as long as the receiver holds ready low,
// and no input is taken until the last word is taken.
// After the eighth word the hash state, fill and length return to the
// initial values. Reset clears the same state and the controller at once;
// no clearing pass is needed.
module sha256_stream_hasher (
	input logic clk,
	input logic arst_n,
	sha_if.sink   in_req,
	sha_if.source out_rsp
);
	import sha_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [31:0] word;
	logic [2:0]  idx;

	sha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_req.valid), .in_ready(in_req.ready),
		.in_action(in_req.payload[8]), .in_data(in_req.payload[7:0]),
		.out_valid(out_rsp.valid), .out_ready(out_rsp.ready), .out_index(idx),
		.cmd(cmd), .sts(sts)
	);

	sha_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .digest_word(word)
	);

	assign out_rsp.payload = {word, idx, idx == 3'd7};
endmodule
